>>> hw/rtl/ile_pkg.sv
// Shared types, sizes and codes for the indexed list engine.
// Used by every module of the block but ile_ram; depends on nothing else.
`default_nettype none

package ile_pkg;

   // Number of entries the list can hold.
   localparam int DEPTH = 32;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   // Width wide enough for both a count and a 6-bit position.
   localparam int LEN_W  = (CNT_W > 6) ? CNT_W : 6;

   localparam logic [2:0] FUNC_READ     = 3'd0;
   localparam logic [2:0] FUNC_INS_HEAD = 3'd1;
   localparam logic [2:0] FUNC_INS_TAIL = 3'd2;
   localparam logic [2:0] FUNC_INS_AT   = 3'd3;
   localparam logic [2:0] FUNC_DELETE   = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic signed [31:0] NO_VALUE = 32'shFFFF_FFFF;
   localparam logic [5:0] FULL_COUNT = 6'(DEPTH % 64);

   typedef struct packed {
      logic [2:0]         func;
      logic [5:0]         position;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [5:0]         count_after;
   } rsp_type;

   typedef enum logic [2:0] {
      OUT_READ,
      OUT_INSERT,
      OUT_DELETE,
      OUT_RANGE,
      OUT_FULL
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SHIFT,
      ST_PLACE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic step;
      logic place;
      logic publish;
   } ctl_cmd_type;

   typedef struct packed {
      outcome_type outcome;
      logic        shift_insert;
      logic        more;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ile_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the list storage.
`default_nettype none

module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ile_datapath.sv
// Datapath of the indexed list engine: request and count registers, the
// shift address counter, the list RAM and the result register.
// Depends on ile_pkg and ile_ram.
`default_nettype none

module ile_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ile_pkg::req_type      req_data,
   input  wire ile_pkg::ctl_cmd_type  cmd,
   output ile_pkg::dp_status_type     status,
   output ile_pkg::rsp_type           rsp_data
);

   ile_pkg::req_type     req_ff;
   ile_pkg::outcome_type outcome_ff;
   ile_pkg::outcome_type outcome;
   ile_pkg::rsp_type     rsp_ff;
   ile_pkg::rsp_type     rsp_in;

   logic [ile_pkg::CNT_W-1:0]  count_ff;
   logic [ile_pkg::CNT_W-1:0]  count_in;
   logic [ile_pkg::CNT_W-1:0]  count_dec;
   logic [ile_pkg::ADDR_W-1:0] idx_ff;
   logic [ile_pkg::ADDR_W-1:0] stop_ff;
   logic [ile_pkg::ADDR_W-1:0] wr_addr_ff;
   logic                       pend_ff;

   logic [ile_pkg::LEN_W-1:0]  count_ext;
   logic [ile_pkg::LEN_W-1:0]  pos_ext;
   logic [ile_pkg::LEN_W-1:0]  tpos_ext;
   logic [ile_pkg::LEN_W-1:0]  count_out_ext;
   logic [ile_pkg::ADDR_W-1:0] tpos_a;
   logic [ile_pkg::ADDR_W-1:0] pos_a;
   logic [ile_pkg::ADDR_W-1:0] count_a;
   logic [ile_pkg::ADDR_W-1:0] dec_a;
   logic                       shift_insert;

   logic                       ram_wr_en;
   logic [ile_pkg::ADDR_W-1:0] ram_wr_addr;
   logic [31:0]                ram_wr_data;
   logic                       ram_rd_en;
   logic [ile_pkg::ADDR_W-1:0] ram_rd_addr;
   logic [31:0]                ram_rd_data;

   assign count_ext = ile_pkg::LEN_W'(count_ff);
   assign pos_ext   = ile_pkg::LEN_W'(req_ff.position);
   assign count_dec = count_ff - ile_pkg::CNT_W'(1);
   assign pos_a     = pos_ext[ile_pkg::ADDR_W-1:0];
   assign tpos_a    = tpos_ext[ile_pkg::ADDR_W-1:0];
   assign count_a   = count_ext[ile_pkg::ADDR_W-1:0];
   assign dec_a     = count_dec[ile_pkg::ADDR_W-1:0];
   assign shift_insert = (outcome_ff == ile_pkg::OUT_INSERT);

   // Classify the held request against the current count. The position
   // check for inserts comes before the full check.
   always_comb begin
      tpos_ext = pos_ext;
      outcome  = ile_pkg::OUT_RANGE;
      case (req_ff.func)
         ile_pkg::FUNC_READ: begin
            outcome = (pos_ext < count_ext) ? ile_pkg::OUT_READ : ile_pkg::OUT_RANGE;
         end
         ile_pkg::FUNC_INS_HEAD, ile_pkg::FUNC_INS_TAIL, ile_pkg::FUNC_INS_AT: begin
            if (req_ff.func == ile_pkg::FUNC_INS_HEAD) begin
               tpos_ext = '0;
            end else if (req_ff.func == ile_pkg::FUNC_INS_TAIL) begin
               tpos_ext = count_ext;
            end
            if (tpos_ext > count_ext) begin
               outcome = ile_pkg::OUT_RANGE;
            end else if (count_ext == ile_pkg::LEN_W'(ile_pkg::DEPTH)) begin
               outcome = ile_pkg::OUT_FULL;
            end else begin
               outcome = ile_pkg::OUT_INSERT;
            end
         end
         ile_pkg::FUNC_DELETE: begin
            outcome = (pos_ext < count_ext) ? ile_pkg::OUT_DELETE : ile_pkg::OUT_RANGE;
         end
         default: begin
            outcome = ile_pkg::OUT_RANGE;
         end
      endcase
   end

   assign status.outcome      = outcome;
   assign status.shift_insert = shift_insert;
   assign status.more         = (idx_ff != stop_ff);

   // Each shift step reads the neighbor of idx and writes it into idx in the
   // next cycle, so one entry moves per cycle.
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_a;
      if (cmd.step) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = shift_insert ? (idx_ff - ile_pkg::ADDR_W'(1))
                                    : (idx_ff + ile_pkg::ADDR_W'(1));
      end else if (cmd.decide && (outcome == ile_pkg::OUT_READ)) begin
         ram_rd_en = 1'b1;
      end
   end

   assign ram_wr_en   = pend_ff | cmd.place;
   assign ram_wr_addr = cmd.place ? stop_ff : wr_addr_ff;
   assign ram_wr_data = cmd.place ? req_ff.item_value : ram_rd_data;

   ile_ram #(
      .WIDTH (32),
      .DEPTH (ile_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (outcome_ff)
         ile_pkg::OUT_INSERT: count_in = count_ff + ile_pkg::CNT_W'(1);
         ile_pkg::OUT_DELETE: count_in = count_dec;
         default:             count_in = count_ff;
      endcase
      count_out_ext      = ile_pkg::LEN_W'(count_in);
      rsp_in.read_value  = (outcome_ff == ile_pkg::OUT_READ) ? ram_rd_data
                                                             : ile_pkg::NO_VALUE;
      case (outcome_ff)
         ile_pkg::OUT_RANGE: rsp_in.status = ile_pkg::STATUS_RANGE;
         ile_pkg::OUT_FULL:  rsp_in.status = ile_pkg::STATUS_FULL;
         default:            rsp_in.status = ile_pkg::STATUS_DONE;
      endcase
      rsp_in.count_after = count_out_ext[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= cmd.step;
         if (cmd.publish) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.decide) begin
         outcome_ff <= outcome;
         if (outcome == ile_pkg::OUT_INSERT) begin
            idx_ff  <= count_a;
            stop_ff <= tpos_a;
         end else begin
            idx_ff  <= pos_a;
            stop_ff <= dec_a;
         end
      end else if (cmd.step) begin
         wr_addr_ff <= idx_ff;
         idx_ff     <= shift_insert ? (idx_ff - ile_pkg::ADDR_W'(1))
                                    : (idx_ff + ile_pkg::ADDR_W'(1));
      end
      if (cmd.publish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ile_ctrl.sv
// Controller of the indexed list engine: sequences decode, entry shifts,
// the final write and the result transfer.
// Depends on ile_pkg.
`default_nettype none

module ile_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire ile_pkg::dp_status_type status,
   output ile_pkg::ctl_cmd_type       cmd
);

   ile_pkg::state_type state_ff;
   ile_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ile_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ile_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ile_pkg::ST_DECODE;
            end
         end
         ile_pkg::ST_DECODE: begin
            cmd.decide = 1'b1;
            if ((status.outcome == ile_pkg::OUT_INSERT) ||
                (status.outcome == ile_pkg::OUT_DELETE)) begin
               state_in = ile_pkg::ST_SHIFT;
            end else begin
               state_in = ile_pkg::ST_RESPOND;
            end
         end
         ile_pkg::ST_SHIFT: begin
            // The last pending write drains in the cycle that sees no more steps.
            if (status.more) begin
               cmd.step = 1'b1;
            end else if (status.shift_insert) begin
               state_in = ile_pkg::ST_PLACE;
            end else begin
               state_in = ile_pkg::ST_RESPOND;
            end
         end
         ile_pkg::ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ile_pkg::ST_RESPOND;
         end
         ile_pkg::ST_RESPOND: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ile_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ile_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/indexed_list_engine_top.sv
// Indexed list engine: an ordered list of signed 32-bit values in one RAM.
// A read or a rejected request goes from decode straight to the result; an insert first
// moves the entries from its position onward one place toward the tail and then writes
// the new value, and a delete moves the entries after its position one place toward the
// head. One item is in work at a time, held longer while an earlier result waits on a stalled receiver.
// Synchronous reset empties the list and clears the result valid flag.
`default_nettype none

module indexed_list_engine_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ile_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ile_pkg::rsp_type      rsp_data
);

   ile_pkg::ctl_cmd_type  cmd;
   ile_pkg::dp_status_type status;

   ile_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ile_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/ile_checker.sv
// Port-level checks for the indexed list engine, bound to the top level.
// Depends on ile_pkg and indexed_list_engine_top.
`default_nettype none

module ile_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ile_pkg::rsp_type rsp_data
);

   // No result may be offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only a successful read carries a value.
   a_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ile_pkg::STATUS_DONE))
         |-> (rsp_data.read_value == ile_pkg::NO_VALUE))
      else $error("failed request returned a value");

   // A dropped insert reports a full list.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ile_pkg::STATUS_FULL))
         |-> (rsp_data.count_after == ile_pkg::FULL_COUNT))
      else $error("full status with wrong count");

   // The engine takes one request at a time.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
